// File: design/spt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package spt_pkg;
  localparam int unsigned TableDepthDefault = 64;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_LOOKUP = 3'd2,
    OP_TOTAL  = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_DECIDE,
    S_INS_RD,
    S_INS_WR,
    S_REM_RD,
    S_REM_WR,
    S_TOT_RD,
    S_TOT_ACC,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] size;
    logic [7:0]  pstate;
    logic [31:0] seq;
  } entry_t;
endpackage
`default_nettype wire

// File: design/sorted_page_table_top.sv
`timescale 1ns / 1ps
`default_nettype none
// sorted page table: entries kept sorted by ascending offset in one memory
// input channel (in_valid_i/in_ready_o) carries op, offset, pg_bytes,
// pg_code and seq_no; each transaction yields one result on the
// output channel (out_valid_o/out_ready_i): status, hit, size_out,
// total_active and entries_used
// cfg channel (cfg_valid_i/cfg_ready_o) writes active_state_code; ready always
// one item at a time; each step reads the entry memory, then uses the registered read data:
//   search: binary search, a read and a compare per search step
//   insert/remove: search plus a read and a write per shifted entry
//   total: a read and an accumulate per entry in use
//   clear: straight to the result
// reset empties the table (fill count 0, no memory sweep) and sets the
// active code to 0; memory contents are left as they are
// a finished result stays in the output register until taken; the next
// input transaction is accepted meanwhile, and its own result waits in the
// last state until the output register is free
module sorted_page_table_top #(
  parameter int unsigned TABLE_DEPTH = spt_pkg::TableDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  op_i,
  input  wire logic [31:0] offset_i,
  input  wire logic [31:0] pg_bytes_i,
  input  wire logic [7:0]  pg_code_i,
  input  wire logic [31:0] seq_no_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic             hit_o,
  output logic [31:0]      size_out_o,
  output logic [31:0]      total_active_o,
  output logic [6:0]       entries_used_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  active_state_code_i
);
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);

  spt_pkg::state_e state_q, state_d;
  spt_pkg::entry_t mem [TABLE_DEPTH];
  spt_pkg::entry_t rd_q;
  logic            we;
  logic [AW-1:0]   waddr, raddr;
  spt_pkg::entry_t wdata;

  logic [CW-1:0] fill_q, fill_d;
  logic [CW-1:0] lo_q, lo_d, hi_q, hi_d, idx_q, idx_d;
  logic          found_q, found_d;
  logic [7:0]    act_q;
  logic [2:0]    op_q;
  spt_pkg::entry_t in_q;
  logic [31:0]   tot_q, tot_d;
  logic [CW-1:0] mid;

  logic [1:0]  st_q, st_d;
  logic        hit_q, hit_d;
  logic [31:0] so_q, so_d;
  logic [31:0] tout_q, tout_d;
  logic [6:0]  used_q, used_d;
  logic        ov_q, ov_d;

  assign mid = lo_q + ((hi_q - lo_q) >> 1);
  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == spt_pkg::S_IDLE);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spt_pkg::S_IDLE;
      fill_q  <= '0;
      act_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      ov_q    <= ov_d;
      if (cfg_valid_i) begin
        act_q <= active_state_code_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    idx_q   <= idx_d;
    found_q <= found_d;
    tot_q   <= tot_d;
    st_q    <= st_d;
    hit_q   <= hit_d;
    so_q    <= so_d;
    tout_q  <= tout_d;
    used_q  <= used_d;
    if (in_valid_i && in_ready_o) begin
      op_q        <= op_i;
      in_q.key    <= offset_i;
      in_q.size   <= pg_bytes_i;
      in_q.pstate <= pg_code_i;
      in_q.seq    <= seq_no_i;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      spt_pkg::S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          if (op_i == spt_pkg::OP_TOTAL) begin
            state_d = spt_pkg::S_TOT_RD;
          end else if (op_i == spt_pkg::OP_INSERT || op_i == spt_pkg::OP_REMOVE ||
                       op_i == spt_pkg::OP_LOOKUP) begin
            state_d = spt_pkg::S_SRCH_RD;
          end else begin
            state_d = spt_pkg::S_DONE;
          end
        end
      end
      spt_pkg::S_SRCH_RD:  state_d = (lo_q < hi_q) ? spt_pkg::S_SRCH_CMP : spt_pkg::S_DECIDE;
      spt_pkg::S_SRCH_CMP: state_d = (rd_q.key == in_q.key) ? spt_pkg::S_DECIDE
                                                              : spt_pkg::S_SRCH_RD;
      spt_pkg::S_DECIDE: begin
        if (op_q == spt_pkg::OP_INSERT && !found_q && fill_q < DepthC) begin
          state_d = spt_pkg::S_INS_RD;
        end else if (op_q == spt_pkg::OP_REMOVE && found_q) begin
          state_d = spt_pkg::S_REM_RD;
        end else begin
          state_d = spt_pkg::S_DONE;
        end
      end
      spt_pkg::S_INS_RD:  state_d = spt_pkg::S_INS_WR;
      spt_pkg::S_INS_WR:  state_d = (idx_q == lo_q) ? spt_pkg::S_DONE : spt_pkg::S_INS_RD;
      spt_pkg::S_REM_RD:  state_d = (idx_q + 1'b1 < fill_q) ? spt_pkg::S_REM_WR
                                                            : spt_pkg::S_DONE;
      spt_pkg::S_REM_WR:  state_d = spt_pkg::S_REM_RD;
      spt_pkg::S_TOT_RD:  state_d = (idx_q < fill_q) ? spt_pkg::S_TOT_ACC : spt_pkg::S_DONE;
      spt_pkg::S_TOT_ACC: state_d = spt_pkg::S_TOT_RD;
      spt_pkg::S_DONE:    state_d = (ov_q && !out_ready_i) ? spt_pkg::S_DONE
                                                           : spt_pkg::S_IDLE;
      default:            state_d = spt_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    lo_d    = lo_q;
    hi_d    = hi_q;
    idx_d   = idx_q;
    found_d = found_q;
    tot_d   = tot_q;
    fill_d  = fill_q;
    st_d    = st_q;
    hit_d   = hit_q;
    so_d    = so_q;
    tout_d  = tout_q;
    used_d  = used_q;
    ov_d    = ov_q;
    we      = 1'b0;
    waddr   = '0;
    wdata   = in_q;
    raddr   = '0;
    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end
    unique case (state_q)
      spt_pkg::S_IDLE: begin
        lo_d    = '0;
        hi_d    = fill_q;
        idx_d   = '0;
        found_d = 1'b0;
        tot_d   = '0;
      end
      spt_pkg::S_SRCH_RD: begin
        raddr = mid[AW-1:0];
        idx_d = mid;
      end
      spt_pkg::S_SRCH_CMP: begin
        if (rd_q.key == in_q.key) begin
          found_d = 1'b1;
          lo_d    = idx_q;
        end else if (rd_q.key < in_q.key) begin
          lo_d = idx_q + 1'b1;
        end else begin
          hi_d = idx_q;
        end
      end
      spt_pkg::S_DECIDE: begin
        raddr = lo_q[AW-1:0];
        idx_d = fill_q;
        if (op_q == spt_pkg::OP_REMOVE) begin
          idx_d = lo_q;
        end
        if (op_q == spt_pkg::OP_INSERT && found_q) begin
          we    = 1'b1;
          waddr = lo_q[AW-1:0];
          wdata = '{key: in_q.key, size: in_q.size, pstate: in_q.pstate, seq: in_q.seq};
        end
      end
      spt_pkg::S_INS_RD: begin
        if (idx_q != lo_q) begin
          raddr = AW'(idx_q - 1'b1);
        end
      end
      spt_pkg::S_INS_WR: begin
        we    = 1'b1;
        waddr = idx_q[AW-1:0];
        if (idx_q != lo_q) begin
          wdata = rd_q;
          idx_d = idx_q - 1'b1;
        end
      end
      spt_pkg::S_REM_RD: begin
        if (idx_q + 1'b1 < fill_q) begin
          raddr = AW'(idx_q + 1'b1);
        end else begin
          fill_d = fill_q - 1'b1;
        end
      end
      spt_pkg::S_REM_WR: begin
        we    = 1'b1;
        waddr = idx_q[AW-1:0];
        wdata = rd_q;
        idx_d = idx_q + 1'b1;
      end
      spt_pkg::S_TOT_RD: begin
        raddr = idx_q[AW-1:0];
      end
      spt_pkg::S_TOT_ACC: begin
        if (rd_q.pstate == act_q) begin
          tot_d = tot_q + rd_q.size;
        end
        idx_d = idx_q + 1'b1;
      end
      spt_pkg::S_DONE: begin
        raddr = lo_q[AW-1:0];
        if (!ov_q || out_ready_i) begin
          ov_d  = 1'b1;
          st_d  = spt_pkg::ST_OK;
          hit_d = 1'b0;
          so_d  = '0;
          case (op_q)
            spt_pkg::OP_INSERT: begin
              hit_d = found_q;
              if (!found_q) begin
                if (fill_q == DepthC) st_d = spt_pkg::ST_FULL;
                else fill_d = fill_q + 1'b1;
              end
            end
            spt_pkg::OP_REMOVE: begin
              hit_d = found_q;
              if (!found_q) st_d = spt_pkg::ST_MISS;
            end
            spt_pkg::OP_LOOKUP: begin
              hit_d = found_q;
              if (found_q) so_d = rd_q.size;
              else st_d = spt_pkg::ST_MISS;
            end
            spt_pkg::OP_CLEAR: fill_d = '0;
            default: ;
          endcase
          tout_d = (op_q == spt_pkg::OP_TOTAL) ? tot_q : '0;
          used_d = 7'(fill_d);
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o    = ov_q;
  assign status_o       = st_q;
  assign hit_o          = hit_q;
  assign size_out_o     = so_q;
  assign total_active_o = tout_q;
  assign entries_used_o = used_q;

`ifndef ASSERT_OFF
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= DepthC) else $error("fill count beyond depth");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != spt_pkg::S_IDLE) |-> !in_ready_o) else $error("accept while busy");
  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != spt_pkg::S_DONE && state_q != spt_pkg::S_INS_WR &&
     state_q != spt_pkg::S_REM_RD) |=> $stable(fill_q)) else $error("fill moved");
  a_done_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == spt_pkg::S_DONE) |=> out_valid_o) else $error("result lost");
`endif
endmodule
`default_nettype wire
